FILE: src/assert_macros.svh
// Assertion helpers used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

FILE: src/dset_pkg.sv
`timescale 1ns / 1ps
package dset_pkg;
   localparam int TABLE_DEPTH_DEF = 64;
   localparam int RANK_W          = 6;
   localparam int ENTRY_COUNT_W   = 7;
   localparam logic [11:0] EARLIEST_YEAR_RST = 12'd2026;

   localparam logic [1:0] CMD_INSERT = 2'd0;
   localparam logic [1:0] CMD_DELETE = 2'd1;
   localparam logic [1:0] CMD_QUERY  = 2'd2;
   localparam logic [1:0] CMD_RANK   = 2'd3;

   localparam logic [2:0] ST_OK         = 3'd0;
   localparam logic [2:0] ST_BAD_DATE   = 3'd1;
   localparam logic [2:0] ST_DUP        = 3'd2;
   localparam logic [2:0] ST_NOT_FOUND  = 3'd3;
   localparam logic [2:0] ST_FULL       = 3'd4;
   localparam logic [2:0] ST_RANK_EMPTY = 3'd5;

   typedef struct packed {
      logic [15:0] id;
      logic [4:0]  day;
      logic [3:0]  month;
      logic [11:0] year;
      logic [7:0]  ini_byte;
   } event_type;

   // classified command handed from front to back
   typedef struct packed {
      logic [1:0]        cmd;
      logic [2:0]        status;
      event_type         ev;
      logic [RANK_W-1:0] rank;
      logic [4:0]        mlen;
      logic [2:0]        wday;
   } op_type;

   function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
      logic [4:0] len;
      case (m)
         4'd2: len = leap ? 5'd29 : 5'd28;
         4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
         default: len = 5'd31;
      endcase
      return len;
   endfunction

   // weekday offset per month
   function automatic logic [2:0] month_offset(input logic [3:0] m);
      logic [2:0] off;
      case (m)
         4'd2: off = 3'd3;
         4'd3: off = 3'd2;
         4'd4: off = 3'd5;
         4'd6: off = 3'd3;
         4'd7: off = 3'd5;
         4'd8: off = 3'd1;
         4'd9: off = 3'd4;
         4'd10: off = 3'd6;
         4'd11: off = 3'd2;
         4'd12: off = 3'd4;
         default: off = 3'd0;
      endcase
      return off;
   endfunction
endpackage

FILE: src/dset_front.sv
`timescale 1ns / 1ps
module dset_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [1:0]          req_command,
   input  logic [15:0]         req_entry_id,
   input  logic [4:0]          req_day,
   input  logic [3:0]          req_month,
   input  logic [11:0]         req_year,
   input  logic [7:0]          req_name_initial,
   input  logic [5:0]          req_rank_index,
   input  logic [11:0]         earliest_year,
   output logic                push_valid,
   input  logic                push_ready,
   output dset_pkg::op_type    push_op
);
   import dset_pkg::*;

   localparam logic [2:0] F_IDLE = 3'd0;
   localparam logic [2:0] F_DIV  = 3'd1;
   localparam logic [2:0] F_CAL  = 3'd2;
   localparam logic [2:0] F_MOD  = 3'd3;
   localparam logic [2:0] F_PUSH = 3'd4;

   logic [2:0]  state_ff, state_in;
   op_type      op_ff, op_in;
   logic [6:0]  q100_ff, q100_in;
   logic [12:0] sum_ff, sum_in;
   logic [10:0] q7_ff, q7_in;

   logic [12:0] base;
   logic [25:0] prod100;
   logic [12:0] r100_raw, r100c;
   logic [6:0]  q100c, q100y, q400y;
   logic        leap, early, month_ok, year_ok, day_ok;
   logic [4:0]  mlen;
   logic [12:0] yy;
   logic [26:0] prod7;
   logic [12:0] r7;

   // year + 400 keeps leap tests intact and year zero positive
   assign base    = 13'(op_ff.ev.year) + 13'd400;
   assign prod100 = 26'(base) * 26'd5242;
   assign prod7   = 27'(sum_ff) * 27'd9362;

   always_comb begin
      r100_raw = base - 13'(q100_ff) * 13'd100;
      if (r100_raw >= 13'd100) begin
         r100c = r100_raw - 13'd100;
         q100c = q100_ff + 7'd1;
      end else begin
         r100c = r100_raw;
         q100c = q100_ff;
      end
      leap     = (op_ff.ev.year[1:0] == 2'd0) && ((r100c != 13'd0) || (q100c[1:0] == 2'd0));
      mlen     = month_len(op_ff.ev.month, leap);
      month_ok = (op_ff.ev.month >= 4'd1) && (op_ff.ev.month <= 4'd12);
      year_ok  = op_ff.ev.year >= earliest_year;
      day_ok   = (op_ff.ev.day != 5'd0) && (op_ff.ev.day <= mlen);
      early    = op_ff.ev.month < 4'd3;
      yy       = base - {12'd0, early};
      q100y    = (early && r100c == 13'd0) ? q100c - 7'd1 : q100c;
      q400y    = (early && r100c == 13'd0 && q100c[1:0] == 2'd0) ?
                 (q100c >> 2) - 7'd1 : (q100c >> 2);
      r7 = sum_ff - 13'(q7_ff) * 13'd7;
      if (r7 >= 13'd7) r7 = r7 - 13'd7;
   end

   always_comb begin
      state_in   = state_ff;
      op_in      = op_ff;
      q100_in    = q100_ff;
      sum_in     = sum_ff;
      q7_in      = q7_ff;
      req_ready  = 1'b0;
      push_valid = 1'b0;
      push_op    = op_ff;
      push_op.wday = r7[2:0];
      unique case (state_ff)
         F_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               op_in.cmd         = req_command;
               op_in.status      = ST_OK;
               op_in.ev.id       = req_entry_id;
               op_in.ev.day      = req_day;
               op_in.ev.month    = req_month;
               op_in.ev.year     = req_year;
               op_in.ev.ini_byte = req_name_initial;
               op_in.rank        = req_rank_index;
               op_in.mlen        = 5'd0;
               op_in.wday        = 3'd0;
               state_in          = F_DIV;
            end
         end
         F_DIV: begin
            q100_in  = prod100[25:19];
            state_in = F_CAL;
         end
         F_CAL: begin
            op_in.mlen = mlen;
            if (op_ff.cmd == CMD_INSERT && !(year_ok && month_ok && day_ok))
               op_in.status = ST_BAD_DATE;
            else if (op_ff.cmd == CMD_QUERY && !(year_ok && month_ok))
               op_in.status = ST_BAD_DATE;
            sum_in = yy + (yy >> 2) - 13'(q100y) + 13'(q400y)
                     + 13'(month_offset(op_ff.ev.month)) + 13'd1;
            state_in = F_MOD;
         end
         F_MOD: begin
            q7_in    = prod7[26:16];
            state_in = F_PUSH;
         end
         F_PUSH: begin
            push_valid = 1'b1;
            if (push_ready) state_in = F_IDLE;
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= F_IDLE;
      else state_ff <= state_in;
   end

   always_ff @(posedge clock) begin
      op_ff   <= op_in;
      q100_ff <= q100_in;
      sum_ff  <= sum_in;
      q7_ff   <= q7_in;
   end
endmodule

FILE: src/dset_queue.sv
`timescale 1ns / 1ps
module dset_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  dset_pkg::op_type push_op,
   output logic             pop_valid,
   input  logic             pop_ready,
   output dset_pkg::op_type pop_op
);
   import dset_pkg::*;

   op_type     slot_ff [2];
   logic       wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [1:0] fill_ff, fill_in;
   logic       do_push, do_pop;

   assign push_ready = fill_ff != 2'd2;
   assign pop_valid  = fill_ff != 2'd0;
   assign pop_op     = slot_ff[rptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wptr_in = do_push ? ~wptr_ff : wptr_ff;
      rptr_in = do_pop ? ~rptr_ff : rptr_ff;
      fill_in = fill_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= 1'b0;
         rptr_ff <= 1'b0;
         fill_ff <= 2'd0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) slot_ff[wptr_ff] <= push_op;
   end
endmodule

FILE: src/dset_back.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module dset_back #(
   parameter int TABLE_DEPTH = dset_pkg::TABLE_DEPTH_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  pop_valid,
   output logic                                  pop_ready,
   input  dset_pkg::op_type                      pop_op,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [2:0]                            rsp_status,
   output logic [15:0]                           rsp_out_id,
   output logic [4:0]                            rsp_out_day,
   output logic [3:0]                            rsp_out_month,
   output logic [11:0]                           rsp_out_year,
   output logic [7:0]                            rsp_out_initial,
   output logic [30:0]                           rsp_day_bitmap,
   output logic [4:0]                            rsp_month_length,
   output logic [2:0]                            rsp_first_weekday,
   output logic [dset_pkg::ENTRY_COUNT_W-1:0]    rsp_entry_count
);
   import dset_pkg::*;

   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam int RW = (CW > RANK_W) ? CW : RANK_W;
   localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

   localparam logic [2:0] B_IDLE  = 3'd0;
   localparam logic [2:0] B_RANK  = 3'd1;
   localparam logic [2:0] B_RANKD = 3'd2;
   localparam logic [2:0] B_SCAN  = 3'd3;
   localparam logic [2:0] B_SHIFT = 3'd4;
   localparam logic [2:0] B_PLACE = 3'd5;
   localparam logic [2:0] B_RESP  = 3'd6;

   event_type mem [TABLE_DEPTH];
   event_type mem_rdata_ff;
   logic          mem_we;
   logic [AW-1:0] mem_waddr, mem_raddr;
   event_type     mem_wdata;

   logic [2:0]    state_ff, state_in;
   op_type        op_ff, op_in;
   logic [CW-1:0] cnt_ff, cnt_in, ia_ff, ia_in, ip_ff, ip_in;
   logic [CW-1:0] rem_ff, rem_in, pos_ff, pos_in;
   logic          dv_ff, dv_in, found_ff, found_in, pos_set_ff, pos_set_in;
   logic [30:0]   bitmap_ff, bitmap_in;
   logic [2:0]    res_status_ff, res_status_in;
   event_type     res_ev_ff, res_ev_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [2:0]    rsp_status_ff, rsp_status_in;
   event_type     rsp_ev_ff, rsp_ev_in;
   logic [30:0]   rsp_bitmap_ff, rsp_bitmap_in;
   logic [4:0]    rsp_mlen_ff, rsp_mlen_in;
   logic [2:0]    rsp_wday_ff, rsp_wday_in;
   logic [ENTRY_COUNT_W-1:0] rsp_cnt_ff, rsp_cnt_in;

   logic [20:0]   key_new, key_e;
   logic [RW-1:0] rank_ext;
   logic [CW-1:0] ip_up, ip_dn;
   logic          st_ok, is_ins;

   assign key_new  = {op_ff.ev.year, op_ff.ev.month, op_ff.ev.day};
   assign key_e    = {mem_rdata_ff.year, mem_rdata_ff.month, mem_rdata_ff.day};
   assign rank_ext = RW'(op_ff.rank);
   assign ip_up    = ip_ff + CW'(1);
   assign ip_dn    = ip_ff - CW'(1);
   assign st_ok    = res_status_ff == ST_OK;
   assign is_ins   = op_ff.cmd == CMD_INSERT;

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      cnt_in        = cnt_ff;
      ia_in         = ia_ff;
      ip_in         = ip_ff;
      rem_in        = rem_ff;
      pos_in        = pos_ff;
      dv_in         = dv_ff;
      found_in      = found_ff;
      pos_set_in    = pos_set_ff;
      bitmap_in     = bitmap_ff;
      res_status_in = res_status_ff;
      res_ev_in     = res_ev_ff;
      pop_ready     = 1'b0;
      mem_we        = 1'b0;
      mem_waddr     = pos_ff[AW-1:0];
      mem_wdata     = op_ff.ev;
      mem_raddr     = ia_ff[AW-1:0];
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_ev_in     = rsp_ev_ff;
      rsp_bitmap_in = rsp_bitmap_ff;
      rsp_mlen_in   = rsp_mlen_ff;
      rsp_wday_in   = rsp_wday_ff;
      rsp_cnt_in    = rsp_cnt_ff;
      unique case (state_ff)
         B_IDLE: begin
            pop_ready = 1'b1;
            if (pop_valid) begin
               op_in         = pop_op;
               res_status_in = pop_op.status;
               res_ev_in     = '0;
               ia_in         = '0;
               dv_in         = 1'b0;
               found_in      = 1'b0;
               pos_in        = cnt_ff;
               pos_set_in    = 1'b0;
               bitmap_in     = '0;
               if (pop_op.status != ST_OK) state_in = B_RESP;
               else if (pop_op.cmd == CMD_RANK) state_in = B_RANK;
               else state_in = B_SCAN;
            end
         end
         B_RANK: begin
            if (rank_ext >= RW'(cnt_ff)) begin
               res_status_in = ST_RANK_EMPTY;
               state_in      = B_RESP;
            end else begin
               mem_raddr = rank_ext[AW-1:0];
               state_in  = B_RANKD;
            end
         end
         B_RANKD: begin
            res_ev_in = mem_rdata_ff;
            state_in  = B_RESP;
         end
         B_SCAN: begin
            // read one entry a cycle, check the one read last cycle
            if (ia_ff < cnt_ff) begin
               ia_in = ia_ff + CW'(1);
               ip_in = ia_ff;
               dv_in = 1'b1;
            end else begin
               dv_in = 1'b0;
            end
            if (dv_ff) begin
               case (op_ff.cmd)
                  CMD_INSERT: begin
                     if (mem_rdata_ff.id == op_ff.ev.id) found_in = 1'b1;
                     if (!pos_set_ff && !(key_new > key_e)) begin
                        pos_in     = ip_ff;
                        pos_set_in = 1'b1;
                     end
                  end
                  CMD_DELETE: begin
                     if (!found_ff && mem_rdata_ff.id == op_ff.ev.id) begin
                        found_in           = 1'b1;
                        pos_in             = ip_ff;
                        res_ev_in.ini_byte = mem_rdata_ff.ini_byte;
                     end
                  end
                  CMD_QUERY: begin
                     if (mem_rdata_ff.year == op_ff.ev.year &&
                         mem_rdata_ff.month == op_ff.ev.month &&
                         mem_rdata_ff.day != 5'd0)
                        bitmap_in = bitmap_ff | (31'd1 << (mem_rdata_ff.day - 5'd1));
                  end
                  default: ;
               endcase
            end
            if (!(ia_ff < cnt_ff) && !dv_ff) begin
               case (op_ff.cmd)
                  CMD_INSERT: begin
                     if (found_ff) begin
                        res_status_in = ST_DUP;
                        state_in      = B_RESP;
                     end else if (cnt_ff >= DEPTH_C) begin
                        res_status_in = ST_FULL;
                        state_in      = B_RESP;
                     end else begin
                        rem_in   = cnt_ff - pos_ff;
                        ia_in    = cnt_ff - CW'(1);
                        state_in = B_SHIFT;
                     end
                  end
                  CMD_DELETE: begin
                     if (!found_ff) begin
                        res_status_in = ST_NOT_FOUND;
                        state_in      = B_RESP;
                     end else begin
                        rem_in   = cnt_ff - pos_ff - CW'(1);
                        ia_in    = pos_ff + CW'(1);
                        state_in = B_SHIFT;
                     end
                  end
                  default: state_in = B_RESP;
               endcase
            end
         end
         B_SHIFT: begin
            // insert moves entries up from the tail, delete moves them down
            if (rem_ff != '0) begin
               ia_in  = is_ins ? ia_ff - CW'(1) : ia_ff + CW'(1);
               ip_in  = ia_ff;
               rem_in = rem_ff - CW'(1);
               dv_in  = 1'b1;
            end else begin
               dv_in = 1'b0;
            end
            if (dv_ff) begin
               mem_we    = 1'b1;
               mem_waddr = is_ins ? ip_up[AW-1:0] : ip_dn[AW-1:0];
               mem_wdata = mem_rdata_ff;
            end
            if (rem_ff == '0 && !dv_ff) begin
               if (is_ins) begin
                  state_in = B_PLACE;
               end else begin
                  cnt_in   = cnt_ff - CW'(1);
                  state_in = B_RESP;
               end
            end
         end
         B_PLACE: begin
            mem_we    = 1'b1;
            mem_waddr = pos_ff[AW-1:0];
            mem_wdata = op_ff.ev;
            cnt_in    = cnt_ff + CW'(1);
            state_in  = B_RESP;
         end
         B_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_ev_in     = (st_ok && op_ff.cmd == CMD_RANK) ? res_ev_ff : '0;
               if (st_ok && op_ff.cmd == CMD_DELETE)
                  rsp_ev_in.ini_byte = res_ev_ff.ini_byte;
               rsp_bitmap_in = (st_ok && op_ff.cmd == CMD_QUERY) ? bitmap_ff : '0;
               rsp_mlen_in   = (st_ok && op_ff.cmd == CMD_QUERY) ? op_ff.mlen : '0;
               rsp_wday_in   = (st_ok && op_ff.cmd == CMD_QUERY) ? op_ff.wday : '0;
               rsp_cnt_in    = ENTRY_COUNT_W'(cnt_ff);
               state_in      = B_IDLE;
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_waddr] <= mem_wdata;
      mem_rdata_ff <= mem[mem_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         dv_ff        <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         dv_ff        <= dv_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      ia_ff         <= ia_in;
      ip_ff         <= ip_in;
      rem_ff        <= rem_in;
      pos_ff        <= pos_in;
      found_ff      <= found_in;
      pos_set_ff    <= pos_set_in;
      bitmap_ff     <= bitmap_in;
      res_status_ff <= res_status_in;
      res_ev_ff     <= res_ev_in;
      rsp_status_ff <= rsp_status_in;
      rsp_ev_ff     <= rsp_ev_in;
      rsp_bitmap_ff <= rsp_bitmap_in;
      rsp_mlen_ff   <= rsp_mlen_in;
      rsp_wday_ff   <= rsp_wday_in;
      rsp_cnt_ff    <= rsp_cnt_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_out_id        = rsp_ev_ff.id;
   assign rsp_out_day       = rsp_ev_ff.day;
   assign rsp_out_month     = rsp_ev_ff.month;
   assign rsp_out_year      = rsp_ev_ff.year;
   assign rsp_out_initial   = rsp_ev_ff.ini_byte;
   assign rsp_day_bitmap    = rsp_bitmap_ff;
   assign rsp_month_length  = rsp_mlen_ff;
   assign rsp_first_weekday = rsp_wday_ff;
   assign rsp_entry_count   = rsp_cnt_ff;

   `ASSERT_IMPLIES(a_cnt_range, clock, reset, 1'b1, cnt_ff <= DEPTH_C)
   `ASSERT_IMPLIES(a_we_state, clock, reset, mem_we, state_ff == B_SHIFT || state_ff == B_PLACE)
   `ASSERT_IMPLIES(a_place_room, clock, reset, state_ff == B_PLACE, cnt_ff < DEPTH_C)
   `ASSERT_NEXT(a_place_inc, clock, reset, state_ff == B_PLACE, cnt_ff == $past(cnt_ff) + CW'(1))
endmodule

FILE: src/date_sorted_event_table_unit.sv
`timescale 1ns / 1ps
// Flow: the front passes each request through its idle, divide, calendar, modulo and push
// states; the back end then scans the one-port table and, for insert and delete, shifts
// entries, while rank reads go straight to the table and rejected dates skip it.
// Throughput: one item at a time in the back end; the front takes no new item until it has
// pushed the last one, and a two-entry queue plus the output register decouple the sides.
// Reset (synchronous, active high): table empty, earliest year 2026, no result pending.
module date_sorted_event_table_unit #(
   parameter int TABLE_DEPTH = dset_pkg::TABLE_DEPTH_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [1:0]                         req_command,
   input  logic [15:0]                        req_entry_id,
   input  logic [4:0]                         req_day,
   input  logic [3:0]                         req_month,
   input  logic [11:0]                        req_year,
   input  logic [7:0]                         req_name_initial,
   input  logic [5:0]                         req_rank_index,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [2:0]                         rsp_status,
   output logic [15:0]                        rsp_out_id,
   output logic [4:0]                         rsp_out_day,
   output logic [3:0]                         rsp_out_month,
   output logic [11:0]                        rsp_out_year,
   output logic [7:0]                         rsp_out_initial,
   output logic [30:0]                        rsp_day_bitmap,
   output logic [4:0]                         rsp_month_length,
   output logic [2:0]                         rsp_first_weekday,
   output logic [dset_pkg::ENTRY_COUNT_W-1:0] rsp_entry_count,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [11:0]                        csr_earliest_year
);
   import dset_pkg::*;

   // earliest accepted year; the user must write it only while idle, which the block leaves unchecked
   logic [11:0] earliest_ff, earliest_in;

   logic   push_valid, push_ready, pop_valid, pop_ready;
   op_type push_op, pop_op;

   assign csr_ready   = 1'b1;
   assign earliest_in = (csr_valid && csr_ready) ? csr_earliest_year : earliest_ff;

   always_ff @(posedge clock) begin
      if (reset) earliest_ff <= EARLIEST_YEAR_RST;
      else earliest_ff <= earliest_in;
   end

   // front: date checks, month length, weekday of the 1st
   dset_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_command      (req_command),
      .req_entry_id     (req_entry_id),
      .req_day          (req_day),
      .req_month        (req_month),
      .req_year         (req_year),
      .req_name_initial (req_name_initial),
      .req_rank_index   (req_rank_index),
      .earliest_year    (earliest_ff),
      .push_valid       (push_valid),
      .push_ready       (push_ready),
      .push_op          (push_op)
   );

   dset_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_op    (push_op),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_op     (pop_op)
   );

   // back: sorted table in memory, scan and shift sequencer, result register
   dset_back #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .pop_valid         (pop_valid),
      .pop_ready         (pop_ready),
      .pop_op            (pop_op),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_out_id        (rsp_out_id),
      .rsp_out_day       (rsp_out_day),
      .rsp_out_month     (rsp_out_month),
      .rsp_out_year      (rsp_out_year),
      .rsp_out_initial   (rsp_out_initial),
      .rsp_day_bitmap    (rsp_day_bitmap),
      .rsp_month_length  (rsp_month_length),
      .rsp_first_weekday (rsp_first_weekday),
      .rsp_entry_count   (rsp_entry_count)
   );
endmodule

FILE: test/date_sorted_event_table_unit_tb.sv
`timescale 1ns / 1ps
module date_sorted_event_table_unit_tb;
   import dset_pkg::*;

   localparam int DEPTH = 64;
   localparam int WATCHDOG_LIMIT = 20000;

   typedef struct packed {
      logic [1:0]  command;
      logic [15:0] entry_id;
      logic [4:0]  day;
      logic [3:0]  month;
      logic [11:0] year;
      logic [7:0]  name_initial;
      logic [5:0]  rank_index;
   } cmd_item_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [15:0] out_id;
      logic [4:0]  out_day;
      logic [3:0]  out_month;
      logic [11:0] out_year;
      logic [7:0]  out_initial;
      logic [30:0] day_bitmap;
      logic [4:0]  month_length;
      logic [2:0]  first_weekday;
      logic [6:0]  entry_count;
   } table_reply_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_command = '0;
   logic [15:0] req_entry_id = '0;
   logic [4:0]  req_day = '0;
   logic [3:0]  req_month = '0;
   logic [11:0] req_year = '0;
   logic [7:0]  req_name_initial = '0;
   logic [5:0]  req_rank_index = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [2:0]  rsp_status;
   logic [15:0] rsp_out_id;
   logic [4:0]  rsp_out_day;
   logic [3:0]  rsp_out_month;
   logic [11:0] rsp_out_year;
   logic [7:0]  rsp_out_initial;
   logic [30:0] rsp_day_bitmap;
   logic [4:0]  rsp_month_length;
   logic [2:0]  rsp_first_weekday;
   logic [6:0]  rsp_entry_count;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [11:0] csr_earliest_year = '0;

   // predictor state
   event_type       sorted_events[DEPTH];
   int              event_total;
   logic [11:0]     year_floor;
   table_reply_type reply_queue[$];

   int  send_idle_pct;
   int  recv_stall_pct;
   bit  failed;
   int  idle_cycles;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   date_sorted_event_table_unit i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_command(req_command), .req_entry_id(req_entry_id),
      .req_day(req_day), .req_month(req_month), .req_year(req_year),
      .req_name_initial(req_name_initial), .req_rank_index(req_rank_index),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_status(rsp_status), .rsp_out_id(rsp_out_id),
      .rsp_out_day(rsp_out_day), .rsp_out_month(rsp_out_month),
      .rsp_out_year(rsp_out_year), .rsp_out_initial(rsp_out_initial),
      .rsp_day_bitmap(rsp_day_bitmap), .rsp_month_length(rsp_month_length),
      .rsp_first_weekday(rsp_first_weekday), .rsp_entry_count(rsp_entry_count),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_earliest_year(csr_earliest_year)
   );

   // --- calendar helpers ---
   function automatic bit leap_year(int y);
      return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
   endfunction

   function automatic int days_in_month(int m, int y);
      if (m == 2) return leap_year(y) ? 29 : 28;
      if (m == 4 || m == 6 || m == 9 || m == 11) return 30;
      return 31;
   endfunction

   // Sakamoto-style weekday of the 1st, year shifted by 400 so year 0 works
   function automatic int weekday_first(int m, int y);
      int offs[12];
      int yy;
      offs = '{0, 3, 2, 5, 0, 3, 5, 1, 4, 6, 2, 4};
      yy = y + 400;
      if (m < 3) yy = yy - 1;
      return (yy + yy / 4 - yy / 100 + yy / 400 + offs[m - 1] + 1) % 7;
   endfunction

   function automatic int key_of(event_type e);
      return (int'(e.year) << 9) | (int'(e.month) << 5) | int'(e.day);
   endfunction

   // applies one command to the predicted table and returns the reply
   function automatic table_reply_type apply_table_cmd(cmd_item_type c);
      table_reply_type r;
      event_type       ev;
      int              pos;
      bit              dup;
      r = '0;
      r.status = ST_OK;
      case (c.command)
         CMD_INSERT: begin
            if (c.year < year_floor || c.month < 1 || c.month > 12 || c.day < 1 ||
                c.day > days_in_month(c.month, c.year)) begin
               r.status = ST_BAD_DATE;
            end else begin
               dup = 0;
               for (int i = 0; i < event_total; i++)
                  if (sorted_events[i].id == c.entry_id) dup = 1;
               if (dup) r.status = ST_DUP;
               else if (event_total >= DEPTH) r.status = ST_FULL;
               else begin
                  ev = '{c.entry_id, c.day, c.month, c.year, c.name_initial};
                  pos = 0;
                  while (pos < event_total && key_of(ev) > key_of(sorted_events[pos]))
                     pos++;
                  for (int i = event_total; i > pos; i--)
                     sorted_events[i] = sorted_events[i - 1];
                  sorted_events[pos] = ev;
                  event_total++;
               end
            end
         end
         CMD_DELETE: begin
            pos = 0;
            while (pos < event_total && sorted_events[pos].id != c.entry_id) pos++;
            if (pos >= event_total) r.status = ST_NOT_FOUND;
            else begin
               r.out_initial = sorted_events[pos].ini_byte;
               for (int i = pos; i + 1 < event_total; i++)
                  sorted_events[i] = sorted_events[i + 1];
               event_total--;
            end
         end
         CMD_QUERY: begin
            if (c.month < 1 || c.month > 12 || c.year < year_floor) r.status = ST_BAD_DATE;
            else begin
               r.month_length = 5'(days_in_month(c.month, c.year));
               r.first_weekday = 3'(weekday_first(c.month, c.year));
               for (int i = 0; i < event_total; i++)
                  if (sorted_events[i].year == c.year && sorted_events[i].month == c.month)
                     r.day_bitmap[sorted_events[i].day - 1] = 1'b1;
            end
         end
         default: begin
            if (c.rank_index >= event_total) r.status = ST_RANK_EMPTY;
            else begin
               r.out_id = sorted_events[c.rank_index].id;
               r.out_day = sorted_events[c.rank_index].day;
               r.out_month = sorted_events[c.rank_index].month;
               r.out_year = sorted_events[c.rank_index].year;
               r.out_initial = sorted_events[c.rank_index].ini_byte;
            end
         end
      endcase
      r.entry_count = 7'(event_total);
      return r;
   endfunction

   // --- driving ---
   // valid drops only in idle cycles, so items can follow back to back
   task automatic send_cmd(cmd_item_type c);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      {req_command, req_entry_id, req_day, req_month, req_year,
       req_name_initial, req_rank_index} <= c;
      reply_queue.push_back(apply_table_cmd(c));
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   // wait for all replies, then a quiet spell covering a full-table scan
   task automatic drain_replies();
      req_valid <= 1'b0;
      while (reply_queue.size() != 0) @(negedge clock);
      repeat (2 * DEPTH + 20) @(negedge clock);
   endtask

   task automatic write_year_floor(logic [11:0] y);
      drain_replies();
      csr_valid <= 1'b1;
      csr_earliest_year <= y;
      do @(posedge clock); while (!csr_ready);
      year_floor = y;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic cmd_item_type mk_cmd(logic [1:0] op, int id, int d, int m, int y,
                                           int ini, int rk);
      cmd_item_type c;
      c = '{op, id[15:0], d[4:0], m[3:0], y[11:0], ini[7:0], rk[5:0]};
      return c;
   endfunction

   // random command; mostly valid dates near the floor and a small id pool
   function automatic cmd_item_type rand_cmd();
      cmd_item_type c;
      logic [63:0]  rnd;
      int           m;
      int           y;
      rnd = {$urandom, $urandom};
      c = rnd[$bits(cmd_item_type)-1:0];
      y = (year_floor + $urandom_range(3) > 4095) ? 4095 : year_floor + $urandom_range(3);
      m = $urandom_range(12, 1);
      if ($urandom_range(9) < 8) begin
         c.year = 12'(y);
         c.month = 4'(m);
         c.day = 5'($urandom_range(days_in_month(m, y), 1));
         c.entry_id = 16'(($urandom_range(9) < 8) ? $urandom_range(90) : $urandom);
         c.rank_index = 6'(($urandom_range(3) == 0) ? $urandom : $urandom_range(event_total));
         c.command = ($urandom_range(9) < 4) ? CMD_INSERT : 2'($urandom_range(3));
      end
      return c;
   endfunction

   // --- checking ---
   always @(posedge clock) begin
      table_reply_type got;
      table_reply_type exp_r;
      if (!reset && rsp_valid && rsp_ready) begin
         got = '{rsp_status, rsp_out_id, rsp_out_day, rsp_out_month, rsp_out_year,
                 rsp_out_initial, rsp_day_bitmap, rsp_month_length, rsp_first_weekday,
                 rsp_entry_count};
         if (reply_queue.size() == 0) begin
            $display("%0t: unexpected reply %h", $time, got);
            failed = 1;
         end else begin
            exp_r = reply_queue.pop_front();
            if (got !== exp_r) begin
               $display("%0t: mismatch expected %h actual %h", $time, exp_r, got);
               failed = 1;
            end
         end
      end
   end

   always @(negedge clock) rsp_ready <= ($urandom_range(99) >= recv_stall_pct);

   // watchdog on cycles with no handshake on any channel
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready))
         idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("date_sorted_event_table_unit test failed");
         $finish;
      end
   end

   // --- tests ---
   task automatic test_directed();
      send_cmd(mk_cmd(CMD_RANK, 0, 0, 0, 0, 0, 0));          // empty table
      send_cmd(mk_cmd(CMD_DELETE, 7, 0, 0, 0, 0, 0));        // absent id
      send_cmd(mk_cmd(CMD_INSERT, 1, 1, 1, 2025, 65, 0));    // below floor
      send_cmd(mk_cmd(CMD_INSERT, 1, 1, 0, 2026, 65, 0));    // month zero
      send_cmd(mk_cmd(CMD_INSERT, 1, 1, 13, 2026, 65, 0));   // month high
      send_cmd(mk_cmd(CMD_INSERT, 1, 0, 5, 2026, 65, 0));    // day zero
      send_cmd(mk_cmd(CMD_INSERT, 1, 31, 4, 2026, 65, 0));   // past month end
      send_cmd(mk_cmd(CMD_INSERT, 1, 29, 2, 2026, 65, 0));   // not leap
      send_cmd(mk_cmd(CMD_INSERT, 1, 29, 2, 2028, 65, 0));
      send_cmd(mk_cmd(CMD_INSERT, 2, 29, 2, 2100, 66, 0));   // century not leap
      send_cmd(mk_cmd(CMD_INSERT, 3, 29, 2, 2400, 0, 0));    // 400 leap, zero initial
      send_cmd(mk_cmd(CMD_INSERT, 4, 29, 2, 2028, 255, 0));  // same date goes first
      send_cmd(mk_cmd(CMD_INSERT, 4, 1, 1, 2030, 1, 0));     // duplicate id
      send_cmd(mk_cmd(CMD_INSERT, 65535, 31, 12, 4095, 200, 0));
      send_cmd(mk_cmd(CMD_QUERY, 0, 0, 2, 2028, 0, 0));
      send_cmd(mk_cmd(CMD_QUERY, 0, 0, 0, 2028, 0, 0));
      send_cmd(mk_cmd(CMD_QUERY, 0, 0, 12, 2025, 0, 0));
      send_cmd(mk_cmd(CMD_RANK, 0, 0, 0, 0, 0, 0));
      send_cmd(mk_cmd(CMD_RANK, 0, 0, 0, 0, 0, 4));
      send_cmd(mk_cmd(CMD_RANK, 0, 0, 0, 0, 0, 63));
      send_cmd(mk_cmd(CMD_DELETE, 3, 0, 0, 0, 0, 0));       // zero initial
      send_cmd(mk_cmd(CMD_DELETE, 65535, 0, 0, 0, 0, 0));
   endtask

   task automatic test_year_zero();
      write_year_floor(12'd0);
      send_cmd(mk_cmd(CMD_INSERT, 9, 29, 2, 0, 90, 0));
      send_cmd(mk_cmd(CMD_QUERY, 0, 0, 1, 0, 0, 0));
      send_cmd(mk_cmd(CMD_QUERY, 0, 0, 2, 0, 0, 0));
      send_cmd(mk_cmd(CMD_QUERY, 0, 0, 3, 4095, 0, 0));
   endtask

   task automatic test_fill_table();
      write_year_floor(12'd4095);
      for (int i = 0; i < DEPTH + 2; i++)
         send_cmd(mk_cmd(CMD_INSERT, 1000 + i, $urandom_range(31, 1), 12, 4095, i, 0));
      send_cmd(mk_cmd(CMD_QUERY, 0, 0, 12, 4095, 0, 0));
      send_cmd(mk_cmd(CMD_RANK, 0, 0, 0, 0, 0, 63));
      for (int i = 0; i < DEPTH; i++) send_cmd(mk_cmd(CMD_DELETE, 1000 + i, 0, 0, 0, 0, 0));
   endtask

   task automatic test_random_phase(int n, int idle_pct, int stall_pct, logic [11:0] floor_y);
      write_year_floor(floor_y);
      send_idle_pct = idle_pct;
      recv_stall_pct = stall_pct;
      repeat (n) send_cmd(rand_cmd());
   endtask

   initial begin
      failed = 0;
      event_total = 0;
      year_floor = EARLIEST_YEAR_RST;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_year_zero();
      test_fill_table();
      test_random_phase(250, 0, 0, 12'd2026);
      test_random_phase(350, 74, 0, 12'd1999);
      test_random_phase(350, 0, 74, 12'd4093);
      test_random_phase(350, 34, 34, 12'd0);
      test_random_phase(100, 0, 0, 12'd2026);
      drain_replies();
      if (!failed) begin
         $display("date_sorted_event_table_unit test passed");
      end else begin
         $display("date_sorted_event_table_unit test failed");
      end
      $finish;
   end
endmodule
